// ===== design/fscan_pkg.sv =====
`default_nettype none
package fscan_pkg;

  localparam int unsigned ARRIVAL_W  = 32;
  localparam int unsigned TRACK_W    = 9;
  localparam int unsigned SECTOR_W   = 4;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LARGEST_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned REQ_W      = ARRIVAL_W + TRACK_W + SECTOR_W + 1 + COUNT_W + TAG_W;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_SERVE  = 1'b1;

  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_DROPPED  = 2'd1;
  localparam logic [1:0] STAT_SERVED   = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SEEK_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_TIME  = 2'd2;

  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [TRACK_W-1:0]   track;
    logic [SECTOR_W-1:0]  sector;
    logic                 is_write;
    logic [COUNT_W-1:0]   count_m1;
    logic [TAG_W-1:0]     tag;
  } fscan_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_SERVE,
    ST_JUMP,
    ST_FRZ_CHK,
    ST_FRZ_WAIT,
    ST_FRZ_END,
    ST_SCAN,
    ST_SEEK,
    ST_DIV_INIT,
    ST_DIV,
    ST_WAIT,
    ST_SUM,
    ST_FINISH
  } fscan_state_e;

  typedef struct packed {
    logic capture;
    logic submit;
    logic drop;
    logic empty_rsp;
    logic jump;
    logic frz_take;
    logic frz_end;
    logic scan_clear;
    logic scan_step;
    logic seek;
    logic div_init;
    logic div_step;
    logic wait_calc;
    logic sum;
    logic finish;
  } fscan_cmd_t;

  typedef struct packed {
    logic queue_full;
    logic queue_empty;
    logic batch_empty;
    logic frz_take;
    logic scan_done;
    logic div_done;
  } fscan_sts_t;

endpackage
`default_nettype wire

// ===== design/fscan_ram.sv =====
`default_nettype none
module fscan_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/fscan_ctrl.sv =====
`default_nettype none
module fscan_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    command_i,
  input  wire fscan_pkg::fscan_sts_t   sts_i,
  output fscan_pkg::fscan_cmd_t        cmd_o,
  output logic                         busy_o
);

  fscan_pkg::fscan_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fscan_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      fscan_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = (command_i == fscan_pkg::CMD_SERVE) ? fscan_pkg::ST_SERVE
                                                         : fscan_pkg::ST_SUBMIT;
        end
      end
      fscan_pkg::ST_SUBMIT: begin
        if (sts_i.queue_full) begin
          cmd_o.drop = 1'b1;
        end else begin
          cmd_o.submit = 1'b1;
        end
        state_d = fscan_pkg::ST_IDLE;
      end
      fscan_pkg::ST_SERVE: begin
        if (sts_i.batch_empty && sts_i.queue_empty) begin
          cmd_o.empty_rsp = 1'b1;
          state_d = fscan_pkg::ST_IDLE;
        end else if (sts_i.batch_empty) begin
          state_d = fscan_pkg::ST_JUMP;
        end else begin
          cmd_o.scan_clear = 1'b1;
          state_d = fscan_pkg::ST_SCAN;
        end
      end
      fscan_pkg::ST_JUMP: begin
        cmd_o.jump = 1'b1;
        state_d = fscan_pkg::ST_FRZ_CHK;
      end
      fscan_pkg::ST_FRZ_CHK: begin
        if (sts_i.frz_take) begin
          cmd_o.frz_take = 1'b1;
          state_d = fscan_pkg::ST_FRZ_WAIT;
        end else begin
          state_d = fscan_pkg::ST_FRZ_END;
        end
      end
      // new queue head is being read
      fscan_pkg::ST_FRZ_WAIT: state_d = fscan_pkg::ST_FRZ_CHK;
      fscan_pkg::ST_FRZ_END: begin
        cmd_o.frz_end    = 1'b1;
        cmd_o.scan_clear = 1'b1;
        state_d = fscan_pkg::ST_SCAN;
      end
      fscan_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = fscan_pkg::ST_SEEK;
        end
      end
      fscan_pkg::ST_SEEK: begin
        cmd_o.seek = 1'b1;
        state_d = fscan_pkg::ST_DIV_INIT;
      end
      fscan_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d = fscan_pkg::ST_DIV;
      end
      fscan_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = fscan_pkg::ST_WAIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      fscan_pkg::ST_WAIT: begin
        cmd_o.wait_calc = 1'b1;
        state_d = fscan_pkg::ST_SUM;
      end
      fscan_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = fscan_pkg::ST_FINISH;
      end
      fscan_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = fscan_pkg::ST_IDLE;
      end
      default: state_d = fscan_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != fscan_pkg::ST_IDLE);

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.finish || cmd_o.submit || cmd_o.drop || cmd_o.empty_rsp)
      |=> state_q == fscan_pkg::ST_IDLE)
    else $error("no return to idle after a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fscan_pkg::ST_DIV && !sts_i.div_done) |=> state_q == fscan_pkg::ST_DIV)
    else $error("remainder unit left before it finished");
`endif

endmodule
`default_nettype wire

// ===== design/fscan_dp.sv =====
`default_nettype none
module fscan_dp #(
  parameter int unsigned QUEUE_DEPTH  = 64,
  parameter int unsigned TRACK_COUNT  = 512,
  parameter int unsigned SECTOR_COUNT = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire fscan_pkg::fscan_cmd_t                 cmd_i,
  output fscan_pkg::fscan_sts_t                      sts_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [fscan_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [fscan_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic [fscan_pkg::ARRIVAL_W-1:0]       arrival_time_i,
  input  wire logic [fscan_pkg::TRACK_W-1:0]         track_i,
  input  wire logic [fscan_pkg::SECTOR_W-1:0]        sector_i,
  input  wire logic                                  is_write_i,
  input  wire logic [fscan_pkg::COUNT_W-1:0]         sector_count_minus_one_i,
  input  wire logic [fscan_pkg::TAG_W-1:0]           tag_i,
  output logic                                       done_o,
  output logic [1:0]                                 status_o,
  output logic [fscan_pkg::TAG_W-1:0]                served_tag_o,
  output logic [fscan_pkg::TIME_W-1:0]               service_time_o,
  output logic [fscan_pkg::TIME_W-1:0]               completion_time_o,
  output logic [fscan_pkg::TIME_W-1:0]               response_time_o,
  output logic [fscan_pkg::TIME_W-1:0]               idle_time_total_o,
  output logic [fscan_pkg::LARGEST_W-1:0]            max_queue_length_o
);

  localparam int unsigned AW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RVW      = $clog2(255 * SECTOR_COUNT + 1);
  localparam int unsigned TrackMax = TRACK_COUNT - 1;
  localparam int unsigned DivSteps = fscan_pkg::TIME_W + 1;

  // configuration
  logic [7:0]  seek_cfg_q, sector_cfg_q;
  logic [15:0] write_cfg_q;

  // queue and batch state
  fscan_pkg::fscan_req_t   in_q, wq_rd, bq_rd, best_q;
  logic [fscan_pkg::REQ_W-1:0] wq_raw, bq_raw;
  logic [AW-1:0]           whead_q, wtail, whead_inc, rd_idx_q, best_idx_q;
  logic [CW-1:0]           wcount_q, batch_left_q;
  logic [QUEUE_DEPTH-1:0]  bvalid_q;
  logic [AW:0]             tail_sum, head_sum, scan_idx_q;
  logic                    rd_vld_q, best_found_q, better;
  logic [31:0]             cur_q, idle_q;
  logic [8:0]              head_track_q;
  logic                    asc_q;
  logic [6:0]              largest_q;

  // service arithmetic
  logic [7:0]              st, st_q;
  logic [8:0]              trk_gap;
  logic [16:0]             seek_q;
  logic [RVW-1:0]          rev_q, target_q, wait_q;
  logic [20:0]             xfer_q;
  logic [32:0]             num_q;
  logic [RVW:0]            rem_q, rem_sh, wsum;
  logic [5:0]              div_cnt_q;
  logic [33:0]             total;
  logic [31:0]             service_q, completion, response;
  logic [32:0]             csum, isum;
  logic [31:0]             n_m1;
  logic [11:0]             target_full;

  // capture shaping
  logic [8:0]              track_sat;
  logic [3:0]              sec_red;

  // result registers
  logic                    done_q;
  logic [1:0]              status_q;
  logic [7:0]              tag_out_q;
  logic [31:0]             service_out_q, completion_q, response_q;

  always_comb begin
    sec_red = sector_i;
    for (int i = 0; i < 8; i++) begin
      if ({28'd0, sec_red} >= SECTOR_COUNT) begin
        sec_red = sec_red - 4'(SECTOR_COUNT);
      end
    end
  end

  assign track_sat = ({23'd0, track_i} > TrackMax) ? 9'(TrackMax) : track_i;

  fscan_ram #(.WIDTH(fscan_pkg::REQ_W), .DEPTH(QUEUE_DEPTH)) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.submit),
    .waddr_i(wtail),
    .wdata_i(in_q),
    .raddr_i(whead_q),
    .rdata_o(wq_raw)
  );

  fscan_ram #(.WIDTH(fscan_pkg::REQ_W), .DEPTH(QUEUE_DEPTH)) u_batch_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.frz_take),
    .waddr_i(batch_left_q[AW-1:0]),
    .wdata_i(wq_rd),
    .raddr_i(scan_idx_q[AW-1:0]),
    .rdata_o(bq_raw)
  );

  assign wq_rd = fscan_pkg::fscan_req_t'(wq_raw);
  assign bq_rd = fscan_pkg::fscan_req_t'(bq_raw);

  assign tail_sum  = (AW+1)'(whead_q) + (AW+1)'(wcount_q);
  assign wtail     = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                     AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
  assign head_sum  = (AW+1)'(whead_q) + (AW+1)'(1);
  assign whead_inc = (head_sum == (AW+1)'(QUEUE_DEPTH)) ? '0 : head_sum[AW-1:0];

  assign better = asc_q ? (bq_rd.track < best_q.track) : (bq_rd.track > best_q.track);

  assign st   = (sector_cfg_q == 8'd0) ? 8'd1 : sector_cfg_q;
  assign trk_gap = (best_q.track >= head_track_q) ? best_q.track - head_track_q
                                                   : head_track_q - best_q.track;
  assign target_full = {8'd0, best_q.sector} * {4'd0, st_q};

  assign rem_sh = {rem_q[RVW-1:0], num_q[32]};
  assign wsum   = (RVW+1)'(target_q) + (RVW+1)'(rev_q) - rem_q;
  assign total  = 34'(seek_q) + 34'(wait_q) + 34'(xfer_q);
  assign csum   = {1'b0, cur_q} + {1'b0, service_q};
  assign completion = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
  assign response   = (completion >= best_q.arrival) ? completion - best_q.arrival : 32'd0;
  assign isum   = {1'b0, idle_q} + {1'b0, wq_rd.arrival - cur_q};
  assign n_m1   = 32'(batch_left_q) - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seek_cfg_q   <= 8'd4;
      sector_cfg_q <= 8'd3;
      write_cfg_q  <= 16'd51;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fscan_pkg::REG_SEEK_TIME:   seek_cfg_q   <= cfg_data_i[7:0];
        fscan_pkg::REG_SECTOR_TIME: sector_cfg_q <= cfg_data_i[7:0];
        fscan_pkg::REG_WRITE_TIME:  write_cfg_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q         <= '0;
      whead_q      <= '0;
      wcount_q     <= '0;
      batch_left_q <= '0;
      bvalid_q     <= '0;
      cur_q        <= '0;
      idle_q       <= '0;
      head_track_q <= '0;
      asc_q        <= 1'b1;
      largest_q    <= '0;
      scan_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.submit | cmd_i.drop | cmd_i.empty_rsp | cmd_i.finish;
      if (cmd_i.capture) begin
        in_q.arrival  <= arrival_time_i;
        in_q.track    <= track_sat;
        in_q.sector   <= sec_red;
        in_q.is_write <= is_write_i;
        in_q.count_m1 <= sector_count_minus_one_i;
        in_q.tag      <= tag_i;
      end
      if (cmd_i.submit) begin
        wcount_q <= wcount_q + CW'(1);
      end
      // idle gap up to the oldest waiting request
      if (cmd_i.jump && (wq_rd.arrival > cur_q)) begin
        idle_q <= isum[32] ? 32'hFFFF_FFFF : isum[31:0];
        cur_q  <= wq_rd.arrival;
      end
      if (cmd_i.frz_take) begin
        bvalid_q[batch_left_q[AW-1:0]] <= 1'b1;
        batch_left_q <= batch_left_q + CW'(1);
        whead_q      <= whead_inc;
        wcount_q     <= wcount_q - CW'(1);
      end
      if (cmd_i.frz_end && (batch_left_q != '0) && (n_m1 > 32'(largest_q))) begin
        largest_q <= (n_m1 > 32'd127) ? 7'd127 : n_m1[6:0];
      end
      if (cmd_i.scan_clear) begin
        scan_idx_q   <= '0;
        rd_vld_q     <= 1'b0;
        best_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (scan_idx_q < (AW+1)'(QUEUE_DEPTH)) begin
          rd_vld_q   <= 1'b1;
          rd_idx_q   <= scan_idx_q[AW-1:0];
          scan_idx_q <= scan_idx_q + (AW+1)'(1);
        end else begin
          rd_vld_q <= 1'b0;
        end
        // strict compare keeps the earlier-frozen entry (lower batch index) on equal tracks
        if (rd_vld_q && bvalid_q[rd_idx_q] && (!best_found_q || better)) begin
          best_found_q <= 1'b1;
          best_idx_q   <= rd_idx_q;
          best_q       <= bq_rd;
        end
      end
      if (cmd_i.finish) begin
        cur_q        <= completion;
        head_track_q <= best_q.track;
        bvalid_q[best_idx_q] <= 1'b0;
        batch_left_q <= batch_left_q - CW'(1);
        if (batch_left_q == CW'(1)) begin
          asc_q <= ~asc_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seek) begin
      st_q   <= st;
      seek_q <= 17'(trk_gap) * 17'(seek_cfg_q);
      rev_q  <= RVW'(32'(st) * SECTOR_COUNT);
    end
    if (cmd_i.div_init) begin
      num_q     <= 33'(cur_q) + 33'(seek_q);
      rem_q     <= '0;
      div_cnt_q <= 6'(DivSteps);
      target_q  <= RVW'(target_full);
      xfer_q    <= 21'({1'b0, best_q.count_m1} + 5'd1) *
                   (best_q.is_write ? 21'(write_cfg_q) : 21'(st_q));
    end
    // restoring remainder, one dividend bit per cycle
    if (cmd_i.div_step) begin
      rem_q     <= (rem_sh >= {1'b0, rev_q}) ? rem_sh - {1'b0, rev_q} : rem_sh;
      num_q     <= {num_q[31:0], 1'b0};
      div_cnt_q <= div_cnt_q - 6'd1;
    end
    if (cmd_i.wait_calc) begin
      wait_q <= (wsum >= {1'b0, rev_q}) ? RVW'(wsum - {1'b0, rev_q}) : wsum[RVW-1:0];
    end
    if (cmd_i.sum) begin
      service_q <= (total[33:32] != 2'd0) ? 32'hFFFF_FFFF : total[31:0];
    end
    if (cmd_i.submit || cmd_i.drop || cmd_i.empty_rsp || cmd_i.finish) begin
      status_q      <= cmd_i.submit ? fscan_pkg::STAT_ACCEPTED :
                       cmd_i.drop   ? fscan_pkg::STAT_DROPPED  :
                       cmd_i.finish ? fscan_pkg::STAT_SERVED   : fscan_pkg::STAT_EMPTY;
      tag_out_q     <= cmd_i.finish ? best_q.tag : 8'd0;
      service_out_q <= cmd_i.finish ? service_q  : 32'd0;
      completion_q  <= cmd_i.finish ? completion : 32'd0;
      response_q    <= cmd_i.finish ? response   : 32'd0;
    end
  end

  assign sts_o.queue_full  = (wcount_q == CW'(QUEUE_DEPTH));
  assign sts_o.queue_empty = (wcount_q == '0);
  assign sts_o.batch_empty = (batch_left_q == '0);
  assign sts_o.frz_take    = (wcount_q != '0) && (wq_rd.arrival <= cur_q);
  assign sts_o.scan_done   = (scan_idx_q == (AW+1)'(QUEUE_DEPTH)) && !rd_vld_q;
  assign sts_o.div_done    = (div_cnt_q == 6'd0);

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign served_tag_o       = tag_out_q;
  assign service_time_o     = service_out_q;
  assign completion_time_o  = completion_q;
  assign response_time_o    = response_q;
  assign idle_time_total_o  = idle_q;
  assign max_queue_length_o = largest_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(bvalid_q) == int'(batch_left_q))
    else $error("batch count out of step with valid bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcount_q <= CW'(QUEUE_DEPTH))
    else $error("waiting count beyond queue depth");
`endif

endmodule
`default_nettype wire

// ===== design/fscan_disk_request_scheduler.sv =====
// submit: captured at start, accepted or dropped in the SUBMIT state, then the registered result strobe
// serve from a frozen batch: a one-entry-a-cycle batch scan, then the bit-serial
// remainder for the rotational position
// serve that freezes a new batch: JUMP, then FRZ_CHK and FRZ_WAIT per request frozen, then FRZ_END
// one item at a time; busy_o is high until the result strobe; results cannot be stalled
// reset clears counters, times and valid bits, loads register defaults, sweep ascending
`default_nettype none
module fscan_disk_request_scheduler #(
  parameter int unsigned QUEUE_DEPTH  = 64,
  parameter int unsigned TRACK_COUNT  = 512,
  parameter int unsigned SECTOR_COUNT = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic                             command_i,
  input  wire logic [fscan_pkg::ARRIVAL_W-1:0]  arrival_time_i,
  input  wire logic [fscan_pkg::TRACK_W-1:0]    track_i,
  input  wire logic [fscan_pkg::SECTOR_W-1:0]   sector_i,
  input  wire logic                             is_write_i,
  input  wire logic [fscan_pkg::COUNT_W-1:0]    sector_count_minus_one_i,
  input  wire logic [fscan_pkg::TAG_W-1:0]      tag_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [fscan_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fscan_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                  done_o,
  output logic [1:0]                            status_o,
  output logic [fscan_pkg::TAG_W-1:0]           served_tag_o,
  output logic [fscan_pkg::TIME_W-1:0]          service_time_o,
  output logic [fscan_pkg::TIME_W-1:0]          completion_time_o,
  output logic [fscan_pkg::TIME_W-1:0]          response_time_o,
  output logic [fscan_pkg::TIME_W-1:0]          idle_time_total_o,
  output logic [fscan_pkg::LARGEST_W-1:0]       max_queue_length_o
);

  fscan_pkg::fscan_cmd_t cmd;
  fscan_pkg::fscan_sts_t sts;

  fscan_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .command_i(command_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  fscan_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TRACK_COUNT (TRACK_COUNT),
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .cfg_we_i                (cfg_we_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .arrival_time_i          (arrival_time_i),
    .track_i                 (track_i),
    .sector_i                (sector_i),
    .is_write_i              (is_write_i),
    .sector_count_minus_one_i(sector_count_minus_one_i),
    .tag_i                   (tag_i),
    .done_o                  (done_o),
    .status_o                (status_o),
    .served_tag_o            (served_tag_o),
    .service_time_o          (service_time_o),
    .completion_time_o       (completion_time_o),
    .response_time_o         (response_time_o),
    .idle_time_total_o       (idle_time_total_o),
    .max_queue_length_o      (max_queue_length_o)
  );

endmodule
`default_nettype wire

// ===== sim/fscan_checker.sv =====
`timescale 1ns / 1ps
module fscan_checker
  import fscan_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = 64,
  parameter int unsigned TRACK_COUNT  = 512,
  parameter int unsigned SECTOR_COUNT = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic                  command_i,
  input  logic [ARRIVAL_W-1:0]  arrival_time_i,
  input  logic [TRACK_W-1:0]    track_i,
  input  logic [SECTOR_W-1:0]   sector_i,
  input  logic                  is_write_i,
  input  logic [COUNT_W-1:0]    sector_count_minus_one_i,
  input  logic [TAG_W-1:0]      tag_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  done_i,
  input  logic [1:0]            status_i,
  input  logic [TAG_W-1:0]      served_tag_i,
  input  logic [TIME_W-1:0]     service_time_i,
  input  logic [TIME_W-1:0]     completion_time_i,
  input  logic [TIME_W-1:0]     response_time_i,
  input  logic [TIME_W-1:0]     idle_time_total_i,
  input  logic [LARGEST_W-1:0]  max_queue_length_i,
  output int                    fail_count_o,
  output int                    outstanding_o
);

  typedef struct packed {
    logic [1:0]           status;
    logic [TAG_W-1:0]     tag;
    logic [TIME_W-1:0]    service;
    logic [TIME_W-1:0]    completion;
    logic [TIME_W-1:0]    response;
    logic [TIME_W-1:0]    idle;
    logic [LARGEST_W-1:0] largest;
  } sched_rsp_t;

  localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF;

  logic [7:0]  seek_per_track;
  logic [7:0]  sector_ticks;
  logic [15:0] write_ticks;

  fscan_req_t  waiting_q [QUEUE_DEPTH];
  int unsigned wait_head, wait_cnt;
  fscan_req_t  batch_q [QUEUE_DEPTH];
  logic        batch_live [QUEUE_DEPTH];
  int unsigned batch_left;
  logic [31:0] now_time;
  logic [8:0]  head_pos;
  logic        sweep_up;
  logic [31:0] idle_sum;
  logic [6:0]  biggest_batch;

  sched_rsp_t  expected_rsp[$];

  assign outstanding_o = expected_rsp.size();

  function automatic logic [31:0] sat32(longint unsigned v);
    return (v > ALL_ONES) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // advance the scheduler state by one item and return the result it gives
  function automatic sched_rsp_t schedule_item(fscan_req_t req, logic cmd);
    sched_rsp_t rsp;
    int best;
    int unsigned n;
    longint unsigned st, rev, trk_gap, seek, pos, tgt, wt, xfer, svc, cmpl;
    rsp = '0;
    if (cmd == CMD_SUBMIT) begin
      if (wait_cnt >= QUEUE_DEPTH) begin
        rsp.status = STAT_DROPPED;
      end else begin
        if (req.track > TRACK_COUNT - 1) req.track = TRACK_COUNT - 1;
        req.sector = req.sector % SECTOR_COUNT;
        waiting_q[(wait_head + wait_cnt) % QUEUE_DEPTH] = req;
        wait_cnt++;
        rsp.status = STAT_ACCEPTED;
      end
    end else if (batch_left == 0 && wait_cnt == 0) begin
      rsp.status = STAT_EMPTY;
    end else begin
      if (batch_left == 0) begin
        if (waiting_q[wait_head].arrival > now_time) begin
          idle_sum = sat32(longint'(idle_sum) + (waiting_q[wait_head].arrival - now_time));
          now_time = waiting_q[wait_head].arrival;
        end
        n = 0;
        while (wait_cnt > 0 && waiting_q[wait_head].arrival <= now_time) begin
          batch_q[n] = waiting_q[wait_head];
          batch_live[n] = 1'b1;
          n++;
          wait_head = (wait_head + 1) % QUEUE_DEPTH;
          wait_cnt--;
        end
        batch_left = n;
        if (n > 0 && n - 1 > biggest_batch) biggest_batch = (n - 1 > 127) ? 127 : n - 1;
      end
      best = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!batch_live[i]) continue;
        if (best < 0) best = i;
        else if (sweep_up && batch_q[i].track < batch_q[best].track) best = i;
        else if (!sweep_up && batch_q[i].track > batch_q[best].track) best = i;
      end
      if (best < 0) begin
        rsp.status = STAT_EMPTY;
      end else begin
        st   = (sector_ticks == 0) ? 1 : sector_ticks;
        rev  = st * SECTOR_COUNT;
        trk_gap = (batch_q[best].track >= head_pos) ? batch_q[best].track - head_pos
                                                    : head_pos - batch_q[best].track;
        seek = trk_gap * seek_per_track;
        pos  = (longint'(now_time) + seek) % rev;
        tgt  = batch_q[best].sector * st;
        wt   = (tgt + rev - pos) % rev;
        xfer = (batch_q[best].count_m1 + 1) * (batch_q[best].is_write ? write_ticks : st);
        svc  = sat32(seek + wt + xfer);
        cmpl = sat32(longint'(now_time) + svc);
        rsp.status     = STAT_SERVED;
        rsp.tag        = batch_q[best].tag;
        rsp.service    = svc[31:0];
        rsp.completion = cmpl[31:0];
        rsp.response   = (cmpl >= batch_q[best].arrival) ? cmpl - batch_q[best].arrival : 0;
        now_time = cmpl[31:0];
        head_pos = batch_q[best].track;
        batch_live[best] = 1'b0;
        batch_left--;
        if (batch_left == 0) sweep_up = !sweep_up;
      end
    end
    rsp.idle    = idle_sum;
    rsp.largest = biggest_batch;
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_rsp_t got, want;
    fscan_req_t req;
    if (!rst_ni) begin
      seek_per_track = 8'd4;
      sector_ticks   = 8'd3;
      write_ticks    = 16'd51;
      wait_head = 0;
      wait_cnt = 0;
      batch_left = 0;
      for (int i = 0; i < QUEUE_DEPTH; i++) batch_live[i] = 1'b0;
      now_time = '0;
      head_pos = '0;
      sweep_up = 1'b1;
      idle_sum = '0;
      biggest_batch = '0;
      fail_count_o = 0;
      expected_rsp.delete();
    end else begin
      if (done_i) begin
        got = '{status_i, served_tag_i, service_time_i, completion_time_i, response_time_i,
                idle_time_total_i, max_queue_length_i};
        if (expected_rsp.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result: status %0d tag %0d",
                                           got.status, got.tag);
        end else begin
          want = expected_rsp.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: exp st %0d tag %0d svc %0d cmp %0d rsp %0d idle %0d max %0d",
                        " / got st %0d tag %0d svc %0d cmp %0d rsp %0d idle %0d max %0d"},
                       want.status, want.tag, want.service, want.completion, want.response,
                       want.idle, want.largest, got.status, got.tag, got.service,
                       got.completion, got.response, got.idle, got.largest);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SEEK_TIME:   seek_per_track = cfg_data_i[7:0];
          REG_SECTOR_TIME: sector_ticks   = cfg_data_i[7:0];
          REG_WRITE_TIME:  write_ticks    = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        req = '{arrival_time_i, track_i, sector_i, is_write_i, sector_count_minus_one_i, tag_i};
        expected_rsp.push_back(schedule_item(req, command_i));
      end
    end
  end

endmodule

// ===== sim/tb_fscan_disk_request_scheduler.sv =====
`timescale 1ns / 1ps
module tb_fscan_disk_request_scheduler;
  import fscan_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned QUEUE_DEPTH_TB = 64;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic                  command_i = CMD_SUBMIT;
  logic [ARRIVAL_W-1:0]  arrival_time_i = '0;
  logic [TRACK_W-1:0]    track_i = '0;
  logic [SECTOR_W-1:0]   sector_i = '0;
  logic                  is_write_i = 1'b0;
  logic [COUNT_W-1:0]    sector_count_minus_one_i = '0;
  logic [TAG_W-1:0]      tag_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [TAG_W-1:0]      served_tag_o;
  logic [TIME_W-1:0]     service_time_o, completion_time_o, response_time_o, idle_time_total_o;
  logic [LARGEST_W-1:0]  max_queue_length_o;
  int                    fail_count, outstanding;
  int unsigned           idle_pct;
  int unsigned           cycle_cnt = 0;
  logic [31:0]           arrival_clock;

  fscan_disk_request_scheduler i_dut (.*);

  fscan_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .command_i, .arrival_time_i, .track_i,
    .sector_i, .is_write_i, .sector_count_minus_one_i, .tag_i, .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .done_i(done_o), .status_i(status_o), .served_tag_i(served_tag_o),
    .service_time_i(service_time_o), .completion_time_i(completion_time_o),
    .response_time_i(response_time_o), .idle_time_total_i(idle_time_total_o),
    .max_queue_length_i(max_queue_length_o), .fail_count_o(fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic issue(logic cmd, logic [31:0] arr, logic [8:0] trk, logic [3:0] sec,
                       logic wr, logic [3:0] cnt, logic [7:0] tg);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    arrival_time_i <= arr;
    track_i <= trk;
    sector_i <= sec;
    is_write_i <= wr;
    sector_count_minus_one_i <= cnt;
    tag_i <= tg;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  task automatic submit_random(bit wide_arrival);
    logic [31:0] arr;
    if (wide_arrival) arr = $urandom;
    else if ($urandom_range(15) == 0) arr = arrival_clock - $urandom_range(200);
    else begin
      arrival_clock += ($urandom_range(9) == 0) ? $urandom_range(5000) : $urandom_range(60);
      arr = arrival_clock;
    end
    issue(CMD_SUBMIT, arr, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic serve();
    issue(CMD_SERVE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    start_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned items, bit wide_arrival);
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 8);
      repeat (burst) submit_random(wide_arrival);
      repeat (burst + $urandom_range(0, 2) - 1) serve();
      sent += 2 * burst;
    end
  endtask

  initial begin
    idle_pct = 0;
    arrival_clock = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty serve, field extremes, idle jump, ties, late arrival
    serve();
    issue(CMD_SUBMIT, 32'd0, 9'd0, 4'd0, 1'b0, 4'd0, 8'd0);
    issue(CMD_SUBMIT, 32'd100, 9'd511, 4'd15, 1'b1, 4'd15, 8'd255);
    issue(CMD_SUBMIT, 32'd20000, 9'd300, 4'd7, 1'b0, 4'd3, 8'd17);
    issue(CMD_SUBMIT, 32'd20000, 9'd300, 4'd2, 1'b1, 4'd1, 8'd18);
    issue(CMD_SUBMIT, 32'd19000, 9'd10, 4'd9, 1'b0, 4'd8, 8'd19);
    repeat (7) serve();
    issue(CMD_SUBMIT, 32'd50000, 9'd256, 4'd8, 1'b1, 4'd0, 8'hAA);
    issue(CMD_SUBMIT, 32'd50000, 9'd255, 4'd1, 1'b0, 4'd15, 8'h55);
    issue(CMD_SUBMIT, 32'd50000, 9'd255, 4'd5, 1'b0, 4'd2, 8'h56);
    repeat (4) serve();
    arrival_clock = 32'd60000;

    // queue overflow: more submits than the queue holds, then drain
    repeat (QUEUE_DEPTH_TB + 2) submit_random(1'b0);
    repeat (QUEUE_DEPTH_TB + 2) serve();

    write_reg(REG_SEEK_TIME, 16'd0);
    write_reg(REG_SECTOR_TIME, 16'd0);
    write_reg(REG_WRITE_TIME, 16'd1);
    write_reg(REG_SPARE, 16'hFFFF);
    run_phase(100, 1'b0);

    idle_pct = 49;
    write_reg(REG_SEEK_TIME, 16'hFFFF);
    write_reg(REG_SECTOR_TIME, 16'h00FF);
    write_reg(REG_WRITE_TIME, 16'hFFFF);
    run_phase(100, 1'b0);

    idle_pct = 35;
    write_reg(REG_SEEK_TIME, 16'd1);
    write_reg(REG_SECTOR_TIME, 16'd1);
    write_reg(REG_WRITE_TIME, 16'd300);
    run_phase(100, 1'b0);

    idle_pct = 0;
    write_reg(REG_SEEK_TIME, 16'd13);
    write_reg(REG_SECTOR_TIME, 16'd7);
    write_reg(REG_WRITE_TIME, 16'd77);
    run_phase(80, 1'b0);

    // full range arrivals drive the clock to saturation
    write_reg(REG_WRITE_TIME, 16'hFFFF);
    run_phase(40, 1'b1);
    arrival_clock = 32'hFFFF_F000;
    run_phase(20, 1'b0);
    issue(CMD_SUBMIT, 32'hFFFF_FFFF, 9'd511, 4'd15, 1'b1, 4'd15, 8'hFF);
    repeat (3) serve();

    start_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
